>>> hw/rtl/pmprc_pkg.sv
// ----------------------------------------------------------------------------
// pmprc_pkg - shared types and constants of the PMP region checker
// Field widths, mode/action/kind codes, control bundle of the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package pmprc_pkg;

	localparam int DEF_ENTRIES   = 64;
	localparam int DEF_ADDR_BITS = 56;

	localparam int IDX_W     = 6;
	localparam int MODE_W    = 2;
	localparam int PERM_BITS = 3;
	localparam int EADDR_W   = 54;
	localparam int AADDR_W   = 56;
	localparam int LEN_W     = 4;
	localparam int KIND_W    = 2;

	// entry address is a word address
	localparam int GRAIN_SHIFT = 2;
	// NA4 region size in bytes
	localparam int NA4_BYTES   = 4;
	// smallest NAPOT region is 8 bytes
	localparam int NAPOT_SHIFT = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF   = 2'd0,
		MODE_TOR   = 2'd1,
		MODE_NA4   = 2'd2,
		MODE_NAPOT = 2'd3
	} mode_t;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_CHECK = 1'b1
	} action_t;

	localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXEC  = 2'd2;

	localparam int PERM_R = 0;
	localparam int PERM_W = 1;
	localparam int PERM_X = 2;

	// control part of one transaction as it moves down the chain
	typedef struct packed {
		logic                 valid;
		action_t              action;
		logic [IDX_W-1:0]     index;
		mode_t                mode;
		logic [PERM_BITS-1:0] perm;
		logic [KIND_W-1:0]    kind;
		logic                 found;
		logic [IDX_W-1:0]     hit_index;
		logic [PERM_BITS-1:0] hit_perm;
	} ctl_t;

	// compare width: holds every bound and the access end, wraps at 64 bits
	function automatic int calc_cw(input int addr_bits);
		int w;
		w = (addr_bits > 57) ? addr_bits : 57;
		return (w + 1 > 64) ? 64 : w + 1;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pmprc_if.sv
// ----------------------------------------------------------------------------
// pmprc_if - request and response channels of the PMP region checker
// Valid/ready channels with the transaction fields as payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmprc_req_if ();
	import pmprc_pkg::*;

	logic               valid;
	logic               ready;
	logic               action;
	logic [IDX_W-1:0]   entry_index;
	logic [MODE_W-1:0]  entry_mode;
	logic               entry_read;
	logic               entry_write;
	logic               entry_exec;
	logic [EADDR_W-1:0] entry_address;
	logic [AADDR_W-1:0] access_address;
	logic [LEN_W-1:0]   access_length;
	logic [KIND_W-1:0]  access_kind;

	modport source (
		output valid, action, entry_index, entry_mode, entry_read, entry_write,
		       entry_exec, entry_address, access_address, access_length, access_kind,
		input  ready
	);
	modport sink (
		input  valid, action, entry_index, entry_mode, entry_read, entry_write,
		       entry_exec, entry_address, access_address, access_length, access_kind,
		output ready
	);
endinterface

interface pmprc_rsp_if ();
	import pmprc_pkg::*;

	logic             valid;
	logic             ready;
	logic             matched;
	logic [IDX_W-1:0] match_index;
	logic             perm_read;
	logic             perm_write;
	logic             perm_exec;
	logic             allowed;

	modport source (
		output valid, matched, match_index, perm_read, perm_write, perm_exec, allowed,
		input  ready
	);
	modport sink (
		input  valid, matched, match_index, perm_read, perm_write, perm_exec, allowed,
		output ready
	);
endinterface

`default_nettype wire

>>> hw/rtl/pmprc_prep.sv
// ----------------------------------------------------------------------------
// pmprc_prep - front stage of the PMP region checker
// Masks addresses, forms access end and NAPOT base/size, feeds the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pmprc_prep #(
	parameter int ADDR_BITS = pmprc_pkg::DEF_ADDR_BITS,
	parameter int CW        = pmprc_pkg::calc_cw(pmprc_pkg::DEF_ADDR_BITS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	pmprc_req_if.sink             req,
	output pmprc_pkg::ctl_t       ctl,
	output logic [CW-1:0]         d0,
	output logic [CW-1:0]         d1,
	output logic [CW-1:0]         d2
);
	import pmprc_pkg::*;

	localparam logic [CW-1:0] AMASK = CW'((65'd1 << ADDR_BITS) - 65'd1);

	ctl_t              ctl_n, ctl_s1;
	logic [CW-1:0]     d0_n, d1_n, d2_n, d0_s1, d1_s1, d2_s1;
	logic [CW-1:0]     base, nstart, nsize, addr, last;
	logic [EADDR_W:0]  incr, pow;
	logic [EADDR_W-1:0] cleared;

	always_comb begin
		base    = CW'({req.entry_address, GRAIN_SHIFT'(0)}) & AMASK;
		// a+1 clears the trailing ones and sets the lowest zero: 2^k
		incr    = {1'b0, req.entry_address} + (EADDR_W+1)'(1);
		pow     = incr & ~{1'b0, req.entry_address};
		cleared = req.entry_address & incr[EADDR_W-1:0];
		nstart  = CW'({cleared, GRAIN_SHIFT'(0)}) & AMASK;
		nsize   = CW'({pow, NAPOT_SHIFT'(0)});
		addr    = CW'(req.access_address) & AMASK;
		last    = addr + CW'(req.access_length);
	end

	always_comb begin
		ctl_n.valid     = req.valid;
		ctl_n.action    = action_t'(req.action);
		ctl_n.index     = req.entry_index;
		ctl_n.mode      = mode_t'(req.entry_mode);
		ctl_n.perm      = {req.entry_exec, req.entry_write, req.entry_read};
		ctl_n.kind      = req.access_kind;
		ctl_n.found     = 1'b0;
		ctl_n.hit_index = '0;
		ctl_n.hit_perm  = '0;
		if (ctl_n.action == ACT_LOAD) begin
			d0_n = base;
			d1_n = nstart;
			d2_n = nsize;
		end else begin
			d0_n = addr;
			d1_n = last;
			d2_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1 <= ctl_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			d0_s1 <= d0_n;
			d1_s1 <= d1_n;
			d2_s1 <= d2_n;
		end
	end

	assign req.ready = advance;
	assign ctl = ctl_s1;
	assign d0  = d0_s1;
	assign d1  = d1_s1;
	assign d2  = d2_s1;

endmodule

`default_nettype wire

>>> hw/rtl/pmprc_cell.sv
// ----------------------------------------------------------------------------
// pmprc_cell - one protection entry of the PMP region checker chain
// Holds one entry, writes it on a matching load, tests passing checks.
// ----------------------------------------------------------------------------
`default_nettype none

module pmprc_cell #(
	parameter int CELL_IDX = 0,
	parameter int CW       = pmprc_pkg::calc_cw(pmprc_pkg::DEF_ADDR_BITS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire pmprc_pkg::ctl_t  ctl_in,
	input  wire logic [CW-1:0]    d0_in,
	input  wire logic [CW-1:0]    d1_in,
	input  wire logic [CW-1:0]    d2_in,
	input  wire logic [CW-1:0]    prev_base,
	output pmprc_pkg::ctl_t       ctl_out,
	output logic [CW-1:0]         d0_out,
	output logic [CW-1:0]         d1_out,
	output logic [CW-1:0]         d2_out,
	output logic [CW-1:0]         base
);
	import pmprc_pkg::*;

	mode_t                mode_q;
	logic [PERM_BITS-1:0] perm_q;
	logic [CW-1:0]        base_q, lo_q, hi_q;

	ctl_t              ctl_n, ctl_s1;
	logic [CW-1:0]     d0_s1, d1_s1, d2_s1;
	logic [CW-1:0]     start, stop, lo_n, step;
	logic              tor, hit, wr;

	// region bounds: TOR takes the neighbor's base, others were set at load
	always_comb begin
		tor   = (mode_q == MODE_TOR);
		start = tor ? prev_base : lo_q;
		stop  = tor ? base_q : hi_q;
		hit   = ctl_in.valid && (ctl_in.action == ACT_CHECK) && !ctl_in.found &&
		        (mode_q != MODE_OFF) && (d0_in >= start) && (d1_in <= stop) &&
		        (!tor || (start <= stop));
		ctl_n = ctl_in;
		if (hit) begin
			ctl_n.found     = 1'b1;
			ctl_n.hit_index = IDX_W'(CELL_IDX);
			ctl_n.hit_perm  = perm_q;
		end
	end

	always_comb begin
		wr   = advance && ctl_in.valid && (ctl_in.action == ACT_LOAD) &&
		       (ctl_in.index == IDX_W'(CELL_IDX));
		lo_n = (ctl_in.mode == MODE_NAPOT) ? d1_in : d0_in;
		step = (ctl_in.mode == MODE_NAPOT) ? d2_in : CW'(NA4_BYTES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
			perm_q <= '0;
			base_q <= '0;
		end else if (wr) begin
			mode_q <= ctl_in.mode;
			perm_q <= ctl_in.perm;
			base_q <= d0_in;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			lo_q <= lo_n;
			hi_q <= lo_n + step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1 <= ctl_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			d0_s1 <= d0_in;
			d1_s1 <= d1_in;
			d2_s1 <= d2_in;
		end
	end

	assign ctl_out = ctl_s1;
	assign d0_out  = d0_s1;
	assign d1_out  = d1_s1;
	assign d2_out  = d2_s1;
	assign base    = base_q;

endmodule

`default_nettype wire

>>> hw/rtl/pmp_region_checker_unit.sv
// ----------------------------------------------------------------------------
// pmp_region_checker_unit - RISC-V physical memory protection checker
// Protection table as a chain of entry cells; first matching region wins.
// ----------------------------------------------------------------------------
// Usage:
//   req  - valid/ready channel. action 0 loads entry entry_index (mode, RWX,
//          word address); action 1 checks access_address/length/kind.
//   rsp  - valid/ready channel, one transaction per request: matched,
//          match_index, the entry's RWX bits and allowed. Loads answer zeros.
//   Throughput: one transaction per cycle while rsp takes them; every request walks the chain.
//   Path: a request passes the front stage register, then one register per
//          entry cell; the last cell's register drives rsp.
//   Requests stay in order: a load updates its cell as it passes, so later
//   checks see it and earlier ones do not.
//   Stall: when rsp holds a transaction that is not taken, the whole chain
//   freezes and req.ready drops in the same cycle.
//   Reset: every entry off with address zero, chain empty; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pmp_region_checker_unit #(
	parameter int ENTRIES   = pmprc_pkg::DEF_ENTRIES,
	parameter int ADDR_BITS = pmprc_pkg::DEF_ADDR_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pmprc_req_if.sink req,
	pmprc_rsp_if.source rsp
);
	import pmprc_pkg::*;

	localparam int CW = calc_cw(ADDR_BITS);

	// chain taps: index 0 is the front stage, index g+1 is cell g's output
	ctl_t          chain_ctl [0:ENTRIES];
	logic [CW-1:0] chain_d0  [0:ENTRIES];
	logic [CW-1:0] chain_d1  [0:ENTRIES];
	logic [CW-1:0] chain_d2  [0:ENTRIES];
	logic [CW-1:0] base_w    [0:ENTRIES-1];
	logic [CW-1:0] prev_w    [0:ENTRIES-1];

	ctl_t          last;
	logic          advance;

	assign last    = chain_ctl[ENTRIES];
	// the last cell's stage is the output register
	assign advance = !last.valid || rsp.ready;

	pmprc_prep #(
		.ADDR_BITS (ADDR_BITS),
		.CW        (CW)
	) u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req),
		.ctl     (chain_ctl[0]),
		.d0      (chain_d0[0]),
		.d1      (chain_d1[0]),
		.d2      (chain_d2[0])
	);

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		// TOR of entry 0 starts at address zero
		if (g == 0) begin : g_first
			assign prev_w[g] = '0;
		end else begin : g_rest
			assign prev_w[g] = base_w[g-1];
		end

		pmprc_cell #(
			.CELL_IDX (g),
			.CW       (CW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.ctl_in    (chain_ctl[g]),
			.d0_in     (chain_d0[g]),
			.d1_in     (chain_d1[g]),
			.d2_in     (chain_d2[g]),
			.prev_base (prev_w[g]),
			.ctl_out   (chain_ctl[g+1]),
			.d0_out    (chain_d0[g+1]),
			.d1_out    (chain_d1[g+1]),
			.d2_out    (chain_d2[g+1]),
			.base      (base_w[g])
		);
	end

	assign rsp.valid       = last.valid;
	assign rsp.matched     = last.found;
	assign rsp.match_index = last.hit_index;
	assign rsp.perm_read   = last.hit_perm[PERM_R];
	assign rsp.perm_write  = last.hit_perm[PERM_W];
	assign rsp.perm_exec   = last.hit_perm[PERM_X];

	// kind code 3 grants nothing; hit_perm is zero when nothing matched
	always_comb begin
		unique case (last.kind)
			KIND_READ:  rsp.allowed = last.hit_perm[PERM_R];
			KIND_WRITE: rsp.allowed = last.hit_perm[PERM_W];
			KIND_EXEC:  rsp.allowed = last.hit_perm[PERM_X];
			default:    rsp.allowed = 1'b0;
		endcase
	end

	// a load never reports a match
	a_load_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		(last.valid && (last.action == ACT_LOAD)) |-> !last.found)
		else $error("load transaction reached the output with a match");

	// the front stage hands over to the first cell whenever the chain moves
	a_front_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_ctl[0].valid && advance) |=> chain_ctl[1].valid)
		else $error("front stage transaction lost at first cell");

	// a match always names an existing entry
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		last.found |-> (last.hit_index <= IDX_W'(ENTRIES - 1)))
		else $error("match index beyond table");

	// nothing enters while a held response blocks the chain
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("request accepted while chain stalled");

endmodule

`default_nettype wire

>>> dv/pmp_region_checker_unit_test.sv
// ----------------------------------------------------------------------------
// pmp_region_checker_unit_test - self-checking bench for the PMP region checker
// Loads protection entries and checks accesses against a mirrored table.
// Directed corners first, then random traffic, backpressure and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pmp_region_checker_unit_test;
	import pmprc_pkg::*;

	localparam int ENTRIES     = DEF_ENTRIES;
	localparam int CYCLE_LIMIT = 400000;
	// long enough to fill the whole entry chain and stall the request side
	localparam int HOLD_CYCLES = 300;

	// RWX bit positions inside a 3-bit permission field
	localparam int BIT_R = 0;
	localparam int BIT_W = 1;
	localparam int BIT_X = 2;

	// kind code with no permission bit behind it
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// one request transaction as the bench sees it
	typedef struct {
		action_t          act;
		bit [IDX_W-1:0]   index;
		mode_t            mode;
		bit [2:0]         perm;
		bit [EADDR_W-1:0] word;
		bit [AADDR_W-1:0] addr;
		bit [LEN_W-1:0]   len;
		bit [KIND_W-1:0]  kind;
	} pmp_request_t;

	// one response transaction
	typedef struct packed {
		logic             matched;
		logic [IDX_W-1:0] index;
		logic             r;
		logic             w;
		logic             x;
		logic             allowed;
	} pmp_verdict_t;

	// Mirror of the protection table plus the verdicts still owed by the block.
	class pmp_table_mirror;
		mode_t            modes[ENTRIES];
		bit [2:0]         perms[ENTRIES];
		bit [EADDR_W-1:0] words[ENTRIES];
		pmp_verdict_t     verdicts_due[$];
		int               errors;
		int               responses;

		function new();
			foreach (modes[i]) begin
				modes[i] = MODE_OFF;
				perms[i] = '0;
				words[i] = '0;
			end
			errors = 0;
			responses = 0;
		endfunction

		function bit [63:0] byte_base(int i);
			return {8'd0, words[i], 2'b00};
		endfunction

		// byte bounds of entry i, access must fit in [lo, hi]; 0 if it holds nothing
		function bit region_bounds(input int i, output bit [63:0] lo, output bit [63:0] hi);
			bit [EADDR_W-1:0] w;
			int k;
			lo = '0;
			hi = '0;
			case (modes[i])
				MODE_TOR: begin
					// previous entry's base whatever its mode
					lo = (i == 0) ? 64'd0 : byte_base(i - 1);
					hi = byte_base(i);
					return lo <= hi;
				end
				MODE_NA4: begin
					lo = byte_base(i);
					hi = lo + NA4_BYTES;
					return 1'b1;
				end
				MODE_NAPOT: begin
					w = words[i];
					k = 0;
					while (k < EADDR_W && w[k])
						k++;
					for (int b = 0; b < k; b++)
						w[b] = 1'b0;
					lo = {8'd0, w, 2'b00};
					hi = lo + (64'd8 << k);
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		endfunction

		function pmp_verdict_t verdict_for(pmp_request_t t);
			pmp_verdict_t v;
			bit [63:0] lo, hi, first, last;
			v = '0;
			if (t.act == ACT_CHECK) begin
				first = {8'd0, t.addr};
				last = first + t.len;
				for (int i = 0; i < ENTRIES; i++) begin
					if (region_bounds(i, lo, hi) && first >= lo && last <= hi) begin
						v.matched = 1'b1;
						v.index = IDX_W'(i);
						v.r = perms[i][BIT_R];
						v.w = perms[i][BIT_W];
						v.x = perms[i][BIT_X];
						v.allowed = (t.kind != KIND_UNUSED) ? perms[i][t.kind] : 1'b0;
						break;
					end
				end
			end
			return v;
		endfunction

		function void note_request(pmp_request_t t);
			verdicts_due.push_back(verdict_for(t));
			if (t.act == ACT_LOAD) begin
				modes[t.index] = t.mode;
				perms[t.index] = t.perm;
				words[t.index] = t.word;
			end
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction

		task report(string msg);
			errors++;
			$display("ERROR: %s", msg);
		endtask

		task compare_field(string name, logic [IDX_W-1:0] got, logic [IDX_W-1:0] want);
			if (got !== want)
				report($sformatf("response %0d: %s is %0h, expected %0h",
					responses, name, got, want));
		endtask

		task check_response(pmp_verdict_t got);
			pmp_verdict_t want;
			if (verdicts_due.size() == 0) begin
				report($sformatf("response %0d arrived with nothing outstanding", responses));
			end else begin
				want = verdicts_due.pop_front();
				compare_field("matched", got.matched, want.matched);
				compare_field("match_index", got.index, want.index);
				compare_field("perm_read", got.r, want.r);
				compare_field("perm_write", got.w, want.w);
				compare_field("perm_exec", got.x, want.x);
				compare_field("allowed", got.allowed, want.allowed);
			end
			responses++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	pmprc_req_if req_ch ();
	pmprc_rsp_if rsp_ch ();

	pmp_region_checker_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	pmp_table_mirror tbl = new();

	// per-cycle idle chance of each side, in percent
	int req_idle_pct = 31;
	int rsp_idle_pct = 31;
	// raised by the stimulus to make the response side hold off for a while
	bit hold_request = 1'b0;
	int cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Transaction builders. Fields the action ignores carry random junk,
	// so the block is also shown not to look at them.
	// ------------------------------------------------------------------
	function automatic pmp_request_t make_load(bit [IDX_W-1:0] idx, mode_t mode,
			bit [2:0] perm, bit [EADDR_W-1:0] word);
		pmp_request_t t;
		t.act = ACT_LOAD;
		t.index = idx;
		t.mode = mode;
		t.perm = perm;
		t.word = word;
		t.addr = AADDR_W'({$urandom, $urandom});
		t.len = LEN_W'($urandom);
		t.kind = KIND_W'($urandom);
		return t;
	endfunction

	function automatic pmp_request_t make_check(bit [AADDR_W-1:0] addr,
			bit [LEN_W-1:0] len, bit [KIND_W-1:0] kind);
		pmp_request_t t;
		t.act = ACT_CHECK;
		t.index = IDX_W'($urandom);
		t.mode = mode_t'(MODE_W'($urandom));
		t.perm = 3'($urandom);
		t.word = EADDR_W'({$urandom, $urandom});
		t.addr = addr;
		t.len = len;
		t.kind = kind;
		return t;
	endfunction

	// Entry loads: many regions sit close to the previous entry, so
	// TOR ranges are sane and regions overlap; NAPOT sizes of every span.
	function automatic pmp_request_t random_load(int idx);
		bit [EADDR_W-1:0] word;
		int k;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel <= 3) begin
			word = ((idx > 0) ? tbl.words[idx - 1] : '0) + EADDR_W'($urandom_range(0, 64));
		end else if (sel <= 6) begin
			k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, EADDR_W)
			                                : $urandom_range(0, 8);
			word = EADDR_W'({$urandom, $urandom});
			for (int b = 0; b < k; b++)
				word[b] = 1'b1;
			if (k < EADDR_W)
				word[k] = 1'b0;
		end else if (sel == 7) begin
			word = ($urandom_range(0, 1) != 0) ? {EADDR_W{1'b1}} : '0;
		end else begin
			word = EADDR_W'({$urandom, $urandom});
		end
		return make_load(IDX_W'(idx), mode_t'($urandom_range(0, 3)),
			3'($urandom_range(0, 7)), word);
	endfunction

	// Checks: most aim at the edges of a live region, the rest anywhere.
	function automatic pmp_request_t random_check();
		bit [63:0] lo, hi, spot;
		bit [LEN_W-1:0] len;
		bit [KIND_W-1:0] kind;
		if ($urandom_range(0, 4) == 0)
			len = LEN_W'($urandom_range(0, 15));
		else if ($urandom_range(0, 1) != 0)
			len = LEN_W'(1 << $urandom_range(0, 3));
		else
			len = LEN_W'($urandom_range(1, 8));
		kind = ($urandom_range(0, 9) == 0) ? KIND_UNUSED : KIND_W'($urandom_range(0, 2));
		if ($urandom_range(0, 9) < 7 &&
		    tbl.region_bounds($urandom_range(0, ENTRIES - 1), lo, hi)) begin
			case ($urandom_range(0, 5))
				0: spot = lo;
				1: spot = lo - 1;
				2: spot = hi - len;
				3: spot = hi - len + 1;
				4: spot = lo + ({$urandom, $urandom} % (hi - lo + 1));
				default: spot = hi - $urandom_range(0, 16);
			endcase
		end else if ($urandom_range(0, 1) != 0) begin
			spot = {$urandom, $urandom};
		end else begin
			spot = $urandom_range(0, 65535);
		end
		return make_check(AADDR_W'(spot), len, kind);
	endfunction

	function automatic pmp_request_t random_item();
		if ($urandom_range(0, 99) < 15)
			return random_load($urandom_range(0, ENTRIES - 1));
		return random_check();
	endfunction

	// ------------------------------------------------------------------
	// Request side. Valid may drop for random idle cycles before a
	// transaction; once raised it holds until the transaction is taken.
	// ------------------------------------------------------------------
	task automatic send_request(input pmp_request_t t);
		while ($urandom_range(0, 99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.action         <= t.act;
		req_ch.entry_index    <= t.index;
		req_ch.entry_mode     <= t.mode;
		req_ch.entry_read     <= t.perm[BIT_R];
		req_ch.entry_write    <= t.perm[BIT_W];
		req_ch.entry_exec     <= t.perm[BIT_X];
		req_ch.entry_address  <= t.word;
		req_ch.access_address <= t.addr;
		req_ch.access_length  <= t.len;
		req_ch.access_kind    <= t.kind;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		tbl.note_request(t);
	endtask

	// stop offering, wait for every owed response, then let the chain empty
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (tbl.pending() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Response side: take a transaction whenever valid and ready met at the
	// edge, then pick ready for the next cycle. A hold request parks ready
	// low for HOLD_CYCLES so the chain backs up into the request side.
	// ------------------------------------------------------------------
	initial begin : response_side
		pmp_verdict_t got;
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.matched = rsp_ch.matched;
				got.index   = rsp_ch.match_index;
				got.r       = rsp_ch.perm_read;
				got.w       = rsp_ch.perm_write;
				got.x       = rsp_ch.perm_exec;
				got.allowed = rsp_ch.allowed;
				tbl.check_response(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		arst_n                <= 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.action         <= ACT_LOAD;
		req_ch.entry_index    <= '0;
		req_ch.entry_mode     <= MODE_OFF;
		req_ch.entry_read     <= 1'b0;
		req_ch.entry_write    <= 1'b0;
		req_ch.entry_exec     <= 1'b0;
		req_ch.entry_address  <= '0;
		req_ch.access_address <= '0;
		req_ch.access_length  <= '0;
		req_ch.access_kind    <= KIND_READ;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed corners ---
		// empty table denies everything
		send_request(make_check('0, 4'd1, KIND_READ));
		// entry 0 TOR from zero up to 0x1000, read only
		send_request(make_load(6'd0, MODE_TOR, 3'b001, 54'h400));
		send_request(make_check('0, 4'd8, KIND_READ));
		send_request(make_check('0, 4'd8, KIND_WRITE));
		// last bytes right up to the end bound, then one byte past it
		send_request(make_check(56'hFF8, 4'd8, KIND_READ));
		send_request(make_check(56'hFF9, 4'd8, KIND_READ));
		// zero-length access sitting on the end bound
		send_request(make_check(56'h1000, 4'd0, KIND_READ));
		// NA4 at 0x2000, write only
		send_request(make_load(6'd1, MODE_NA4, 3'b010, 54'h800));
		send_request(make_check(56'h2000, 4'd4, KIND_WRITE));
		send_request(make_check(56'h2000, 4'd5, KIND_WRITE));
		send_request(make_check(56'h2000, 4'd4, KIND_UNUSED));
		// 64-byte NAPOT at 0x4000, execute only
		send_request(make_load(6'd2, MODE_NAPOT, 3'b100, 54'h1007));
		send_request(make_check(56'h403C, 4'd4, KIND_EXEC));
		send_request(make_check(56'h403C, 4'd8, KIND_EXEC));
		// TOR whose start lies above its end never matches
		send_request(make_load(6'd3, MODE_TOR, 3'b111, '0));
		send_request(make_check(56'h4100, 4'd4, KIND_READ));
		// last entry: NAPOT with an all-ones address spans the whole space
		send_request(make_load(6'd63, MODE_NAPOT, 3'b111, {EADDR_W{1'b1}}));
		send_request(make_check({AADDR_W{1'b1}}, 4'd15, KIND_WRITE));
		send_request(make_check({AADDR_W{1'b1}}, 4'd8, KIND_UNUSED));
		// TOR to the top of the space takes priority over entry 63
		send_request(make_load(6'd62, MODE_TOR, 3'b011, {EADDR_W{1'b1}}));
		send_request(make_check(56'h4100, 4'd4, KIND_READ));
		// switching entry 0 off lets the wide TOR win at address zero
		send_request(make_load(6'd0, MODE_OFF, 3'b111, '0));
		send_request(make_check('0, 4'd8, KIND_READ));
		send_request(make_check(56'h123456789ABCDE, 4'd2, KIND_EXEC));

		// --- fill every entry, then mixed traffic ---
		for (int i = 0; i < ENTRIES; i++)
			send_request(random_load(i));
		repeat (400) send_request(random_item());

		// --- back-to-back stretch, no idling on either side ---
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		repeat (300) send_request(random_item());
		req_idle_pct = 31;
		rsp_idle_pct = 31;

		// --- response side holds off while requests keep coming ---
		hold_request = 1'b1;
		repeat (150) send_request(random_item());

		// --- request side pauses until everything has come back ---
		drain();
		repeat (600) send_request(random_item());

		drain();
		if (tbl.errors == 0 && tbl.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/pmprc_pkg.sv
hw/rtl/pmprc_if.sv
hw/rtl/pmprc_prep.sv
hw/rtl/pmprc_cell.sv
hw/rtl/pmp_region_checker_unit.sv
dv/pmp_region_checker_unit_test.sv
